/* sv/http_start_line_host_field_tagger_assert.svh */
// Assertion macros shared by the tagger modules.
// Included by the queue and back modules; needs no package.
`ifndef HTTP_START_LINE_HOST_FIELD_TAGGER_ASSERT_SVH
`define HTTP_START_LINE_HOST_FIELD_TAGGER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* sv/hst_pkg.sv */
// Shared types and constants of the HTTP start line and Host field tagger.
// No dependencies.
`default_nettype none
package hst_pkg;
  localparam int FirstLineMax = 200;
  localparam int HostMax      = 127;
  localparam int ReasonMax    = 56;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_URI_SKIP, PH_URI, PH_VER_WS, PH_VER_TOK, PH_CODE_WS,
    PH_SIGN, PH_DIGITS, PH_REASON_WS, PH_REASON, PH_DONE
  } fl_phase_t;

  typedef enum logic [2:0] {
    HP_MATCH, HP_SKIP_ST, HP_WINDOW, HP_FOUND, HP_SKIP_LINE, HP_CLOSED
  } host_phase_t;

  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_URI    = 2'd1;
  localparam logic [1:0] ROLE_REASON = 2'd2;
  localparam logic [1:0] ROLE_HOST   = 2'd3;

  // Per-byte classification passed from the front to the back.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       first_line_active;  // byte goes to the first line parser
    logic       is_nl;
    logic       is_ws;
    logic       is_digit;
    logic [7:0] folded;
    logic [7:0] line_offset;
    logic       rep_ok;             // newline seen and length at least 4
    logic [15:0] pkt_len;
  } cls_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] k, input logic [2:0] i);
    logic [63:0] s;
    case (k)
      3'd0: s = "get     ";
      3'd1: s = "post    ";
      3'd2: s = "put     ";
      3'd3: s = "delete  ";
      3'd4: s = "head    ";
      3'd5: s = "options ";
      default: s = "HTTP/   ";
    endcase
    return s[8*(7-i) +: 8];
  endfunction

  function automatic logic [3:0] prefix_len(input logic [2:0] k);
    case (k)
      3'd0: return 4'd4;
      3'd1: return 4'd5;
      3'd2: return 4'd4;
      3'd3: return 4'd7;
      3'd4: return 4'd5;
      3'd5: return 4'd8;
      default: return 4'd5;
    endcase
  endfunction

  function automatic logic [7:0] host_char(input logic [2:0] i);
    logic [39:0] s;
    s = "host:";
    return s[8*(4-i) +: 8];
  endfunction
endpackage
`default_nettype wire

/* sv/hst_front.sv */
// Front end: accepts bytes, counts position and line offset, classifies.
// Uses hst_pkg.
`default_nettype none
module hst_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_payload_byte,
  input  wire logic          in_end_of_packet,
  output logic               q_valid,
  input  wire logic          q_ready,
  output hst_pkg::cls_t      q_data
);
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  off_r, off_nxt;
  logic        nl_r, nl_nxt;
  logic        acc;
  logic [7:0]  b;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign acc      = in_valid && q_ready;
  assign b        = in_payload_byte;

  always_comb begin
    pos_nxt = (pos_r != 16'hFFFF) ? pos_r + 16'd1 : pos_r;
    nl_nxt  = nl_r || (b == 8'h0A);
    off_nxt = (!nl_r && off_r != 8'hFF) ? off_r + 8'd1 : off_r;
    q_data.b = b;
    q_data.last = in_end_of_packet;
    q_data.first_line_active = !nl_r && b != 8'h0A;
    q_data.is_nl = b == 8'h0A;
    q_data.is_ws = b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    q_data.is_digit = b >= 8'h30 && b <= 8'h39;
    q_data.folded = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    q_data.line_offset = off_r;
    q_data.rep_ok = nl_nxt && pos_nxt >= 16'd4;
    q_data.pkt_len = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      off_r <= '0;
      nl_r  <= 1'b0;
    end else if (acc) begin
      if (in_end_of_packet) begin
        pos_r <= '0;
        off_r <= '0;
        nl_r  <= 1'b0;
      end else begin
        pos_r <= pos_nxt;
        off_r <= off_nxt;
        nl_r  <= nl_nxt;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/hst_queue.sv */
// Two-entry queue between front and back; full throughput, registered outputs.
// Uses hst_pkg and the assertion macros.
`default_nettype none
`include "http_start_line_host_field_tagger_assert.svh"
module hst_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire hst_pkg::cls_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output hst_pkg::cls_t      rd_data
);
  hst_pkg::cls_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  `HT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `HT_ASSERT_IMP(a_ptr_match, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r)
  `HT_ASSERT_NEXT(a_full_next, cnt_r == 2'd2 && !rd, cnt_r == 2'd2)
endmodule
`default_nettype wire

/* sv/hst_back.sv */
// Back end: first line and Host line parsers, output register.
// Uses hst_pkg and the assertion macros.
`default_nettype none
`include "http_start_line_host_field_tagger_assert.svh"
module hst_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire hst_pkg::cls_t q_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_byte_role,
  output logic [7:0]         out_echo_byte,
  output logic               out_summary_valid,
  output logic               out_reported,
  output logic [2:0]         out_method_code,
  output logic               out_status_present,
  output logic [9:0]         out_status_code,
  output logic [7:0]         out_uri_length,
  output logic [5:0]         out_reason_length,
  output logic [6:0]         out_host_length,
  output logic [15:0]        out_packet_length
);
  hst_pkg::fl_phase_t   ph_r, ph_nxt;
  hst_pkg::host_phase_t hp_r, hp_nxt;
  logic [6:0] cand_r, cand_nxt;
  logic [9:0] code_r, code_nxt;
  logic       neg_r, neg_nxt, seen_r, seen_nxt;
  logic [7:0] uri_r, uri_nxt;
  logic [5:0] rsn_r, rsn_nxt;
  logic [2:0] meth_r, meth_nxt;
  logic [7:0] kept_r, kept_nxt, pend_r, pend_nxt, win_r, win_nxt;
  logic [1:0] frole, hrole;
  logic       acc, take, reason_go, win_go, hit;
  logic [7:0] b;
  logic [13:0] prod;
  logic [7:0] want, got;
  logic [2:0] off3;

  assign take = !out_valid || out_ready;
  assign q_ready = take;
  assign acc = q_valid && take;
  assign b = q_data.b;

  // First line parser.
  always_comb begin
    ph_nxt = ph_r; cand_nxt = cand_r; code_nxt = code_r; neg_nxt = neg_r;
    seen_nxt = seen_r; uri_nxt = uri_r; rsn_nxt = rsn_r; meth_nxt = meth_r;
    frole = hst_pkg::ROLE_NONE; reason_go = 1'b0; hit = 1'b0;
    off3 = q_data.line_offset[2:0];
    prod = '0; want = '0; got = '0;
    if (q_data.is_nl && !q_data.first_line_active && ph_r != hst_pkg::PH_DONE
        && q_data.line_offset != 8'hFF) begin
      ph_nxt = hst_pkg::PH_DONE;
    end
    if (q_data.is_nl) begin
      ph_nxt = hst_pkg::PH_DONE;
    end else if (q_data.first_line_active && ph_r != hst_pkg::PH_DONE) begin
      if (q_data.line_offset >= 8'(hst_pkg::FirstLineMax) || b == 8'h00) begin
        ph_nxt = hst_pkg::PH_DONE;
      end else begin
        case (ph_r)
          hst_pkg::PH_PREFIX: begin
            cand_nxt = '0;
            // Candidates are checked in order; the first full match wins.
            for (int k = 0; k < 7; k++) begin
              want = hst_pkg::prefix_char(3'(k), off3);
              got = (k < 6) ? q_data.folded : b;
              if (!hit && cand_r[k] && q_data.line_offset < 8'(hst_pkg::prefix_len(3'(k)))
                  && got == want) begin
                if (q_data.line_offset + 8'd1 == 8'(hst_pkg::prefix_len(3'(k)))) begin
                  hit = 1'b1;
                  if (k < 6) begin
                    meth_nxt = 3'(k + 1);
                    ph_nxt = hst_pkg::PH_URI_SKIP;
                  end else begin
                    ph_nxt = hst_pkg::PH_VER_WS;
                  end
                end else begin
                  cand_nxt[k] = 1'b1;
                end
              end
            end
            if (hit) cand_nxt = cand_r;
            else if (cand_nxt == '0) ph_nxt = hst_pkg::PH_DONE;
          end
          hst_pkg::PH_URI_SKIP: begin
            if (b != 8'h20) begin
              ph_nxt = hst_pkg::PH_URI; uri_nxt = uri_r + 8'd1;
              frole = hst_pkg::ROLE_URI;
            end
          end
          hst_pkg::PH_URI: begin
            if (b == 8'h20) ph_nxt = hst_pkg::PH_DONE;
            else begin
              uri_nxt = uri_r + 8'd1; frole = hst_pkg::ROLE_URI;
            end
          end
          hst_pkg::PH_VER_WS: if (!q_data.is_ws) ph_nxt = hst_pkg::PH_VER_TOK;
          hst_pkg::PH_VER_TOK: if (q_data.is_ws) ph_nxt = hst_pkg::PH_CODE_WS;
          hst_pkg::PH_CODE_WS, hst_pkg::PH_SIGN: begin
            if (ph_r == hst_pkg::PH_CODE_WS && q_data.is_ws) begin
              ph_nxt = ph_r;
            end else if (ph_r == hst_pkg::PH_CODE_WS && (b == 8'h2B || b == 8'h2D)) begin
              neg_nxt = b == 8'h2D; ph_nxt = hst_pkg::PH_SIGN;
            end else if (!q_data.is_digit) begin
              ph_nxt = hst_pkg::PH_DONE;
            end else begin
              seen_nxt = 1'b1; code_nxt = {6'd0, b[3:0]};
              ph_nxt = hst_pkg::PH_DIGITS;
            end
          end
          hst_pkg::PH_DIGITS: begin
            if (q_data.is_digit) begin
              prod = 14'(code_r) * 14'd10 + 14'(b[3:0]);
              code_nxt = (prod > 14'd999) ? 10'd999 : prod[9:0];
            end else if (q_data.is_ws) ph_nxt = hst_pkg::PH_REASON_WS;
            else reason_go = 1'b1;
          end
          hst_pkg::PH_REASON_WS: if (!q_data.is_ws) reason_go = 1'b1;
          hst_pkg::PH_REASON: reason_go = 1'b1;
          default: ph_nxt = ph_r;
        endcase
        if (reason_go) begin
          if (b == 8'h0D) ph_nxt = hst_pkg::PH_DONE;
          else begin
            ph_nxt = hst_pkg::PH_REASON;
            if (rsn_r < 6'(hst_pkg::ReasonMax)) begin
              rsn_nxt = rsn_r + 6'd1; frole = hst_pkg::ROLE_REASON;
            end
          end
        end
      end
    end
  end

  // Host line parser.
  always_comb begin
    hp_nxt = hp_r; kept_nxt = kept_r; pend_nxt = pend_r; win_nxt = win_r;
    hrole = hst_pkg::ROLE_NONE; win_go = 1'b0;
    if (hp_r != hst_pkg::HP_FOUND) begin
      if (q_data.is_nl) begin
        if (hp_r == hst_pkg::HP_SKIP_ST || hp_r == hst_pkg::HP_WINDOW ||
            hp_r == hst_pkg::HP_CLOSED) begin
          hp_nxt = hst_pkg::HP_FOUND;
        end else begin
          hp_nxt = hst_pkg::HP_MATCH; kept_nxt = '0; pend_nxt = '0; win_nxt = '0;
        end
      end else begin
        case (hp_r)
          hst_pkg::HP_MATCH: begin
            if (win_r < 8'd5 && q_data.folded == hst_pkg::host_char(win_r[2:0])) begin
              if (win_r == 8'd4) begin
                win_nxt = '0; hp_nxt = hst_pkg::HP_SKIP_ST;
              end else win_nxt = win_r + 8'd1;
            end else hp_nxt = hst_pkg::HP_SKIP_LINE;
          end
          hst_pkg::HP_SKIP_ST: if (b != 8'h20 && b != 8'h09) win_go = 1'b1;
          hst_pkg::HP_WINDOW: win_go = 1'b1;
          default: hp_nxt = hp_r;
        endcase
        if (win_go) begin
          hp_nxt = hst_pkg::HP_WINDOW;
          if (b == 8'h00) hp_nxt = hst_pkg::HP_CLOSED;
          else begin
            if (!(kept_r == 8'd0 && q_data.is_ws)) begin
              hrole = hst_pkg::ROLE_HOST;
              if (q_data.is_ws) pend_nxt = pend_r + 8'd1;
              else begin
                kept_nxt = kept_r + pend_r + 8'd1; pend_nxt = '0;
              end
            end
            win_nxt = win_r + 8'd1;
            if (win_r + 8'd1 >= 8'(hst_pkg::HostMax)) hp_nxt = hst_pkg::HP_CLOSED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && q_data.last)) begin
      ph_r <= hst_pkg::PH_PREFIX; hp_r <= hst_pkg::HP_MATCH;
      cand_r <= '1; code_r <= '0; neg_r <= 1'b0; seen_r <= 1'b0;
      uri_r <= '0; rsn_r <= '0; meth_r <= '0;
      kept_r <= '0; pend_r <= '0; win_r <= '0;
    end else if (acc) begin
      ph_r <= ph_nxt; hp_r <= hp_nxt; cand_r <= cand_nxt; code_r <= code_nxt;
      neg_r <= neg_nxt; seen_r <= seen_nxt; uri_r <= uri_nxt; rsn_r <= rsn_nxt;
      meth_r <= meth_nxt; kept_r <= kept_nxt; pend_r <= pend_nxt; win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (take) out_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_byte_role <= (hrole != hst_pkg::ROLE_NONE) ? hrole : frole;
      out_echo_byte <= b;
      out_summary_valid <= q_data.last;
      out_packet_length <= q_data.last ? q_data.pkt_len : 16'd0;
      out_reported <= q_data.last && q_data.rep_ok;
      if (q_data.last && q_data.rep_ok) begin
        out_method_code <= meth_nxt;
        out_status_present <= seen_nxt;
        out_status_code <= (seen_nxt && !neg_nxt) ? code_nxt : 10'd0;
        out_uri_length <= uri_nxt;
        out_reason_length <= rsn_nxt;
        out_host_length <= (hp_nxt == hst_pkg::HP_FOUND) ? kept_nxt[6:0] : 7'd0;
      end else begin
        out_method_code <= '0; out_status_present <= 1'b0; out_status_code <= '0;
        out_uri_length <= '0; out_reason_length <= '0; out_host_length <= '0;
      end
    end
  end

  `HT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid)
  `HT_ASSERT_IMP(a_rsn_cap, 1'b1, rsn_r <= 6'(hst_pkg::ReasonMax))
  `HT_ASSERT_IMP(a_meth_uri, uri_r != 8'd0, meth_r != 3'd0)
endmodule
`default_nettype wire

/* sv/http_start_line_host_field_tagger.sv */
// HTTP start line and Host field tagger.
// Channels: in_ (payload byte plus end-of-packet flag) and out_ (one result
// word per input word), both valid/ready.
// A front stage counts bytes and classifies each one, a two-word queue
// decouples it from the back stage, which runs the first line and Host line
// parsers and holds the registered result word.
// Path: a word accepted at the input is written into the queue, then moved
// from the queue into the result register that drives out_valid.
// Throughput: one word per cycle while out_ready stays high, set by the
// parser update in the back stage.
// Each word gets a role tag (URI, reason or host) and the echoed byte; the
// final word of a packet carries the summary fields.
// Reset clears all parser state, the queue and the output valid; parser
// state is cleared again after every final word.
// When the receiver stalls, the result word holds, the queue fills, and
// in_ready drops once both queue entries are taken.
// Uses hst_pkg and the front, queue and back modules.
`default_nettype none
module http_start_line_host_field_tagger (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        in_end_of_packet,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_byte_role,
  output logic [7:0]       out_echo_byte,
  output logic             out_summary_valid,
  output logic             out_reported,
  output logic [2:0]       out_method_code,
  output logic             out_status_present,
  output logic [9:0]       out_status_code,
  output logic [7:0]       out_uri_length,
  output logic [5:0]       out_reason_length,
  output logic [6:0]       out_host_length,
  output logic [15:0]      out_packet_length
);
  hst_pkg::cls_t f_data, b_data;
  logic f_valid, f_ready, b_valid, b_ready;

  hst_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_payload_byte, .in_end_of_packet,
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  hst_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  hst_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid, .out_ready, .out_byte_role, .out_echo_byte, .out_summary_valid,
    .out_reported, .out_method_code, .out_status_present, .out_status_code,
    .out_uri_length, .out_reason_length, .out_host_length, .out_packet_length
  );
endmodule
`default_nettype wire

/* tb/http_start_line_host_field_tagger_tb.sv */
// Self-checking testbench of the HTTP start line and Host field tagger.
// Holds a scoreboard class that predicts every result word; needs hst_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module http_start_line_host_field_tagger_tb;

  typedef struct packed {
    logic [1:0]  role;
    logic [7:0]  echo;
    logic        sum_valid;
    logic        reported;
    logic [2:0]  method;
    logic        status_present;
    logic [9:0]  status_code;
    logic [7:0]  uri_len;
    logic [5:0]  reason_len;
    logic [6:0]  host_len;
    logic [15:0] pkt_len;
  } tag_word_t;

  class tag_scoreboard;
    tag_word_t  pending[$];
    int         errors;
    int         packets;
    int         reported_pkts;
    int         hosts_found;
    int         statuses;
    int         methods;
    int unsigned pos;
    int unsigned loff;
    hst_pkg::fl_phase_t   fl;
    logic [6:0]  cand;
    int unsigned code;
    bit          neg;
    bit          seen_status;
    int unsigned uri_cnt;
    int unsigned reason_cnt;
    int unsigned meth;
    hst_pkg::host_phase_t hp;
    int unsigned kept;
    int unsigned trail;
    int unsigned cnt;
    bit          nl_seen;

    function new();
      errors = 0;
      packets = 0;
      reported_pkts = 0;
      hosts_found = 0;
      statuses = 0;
      methods = 0;
      clear();
    endfunction

    function void clear();
      pos = 0;
      loff = 0;
      fl = hst_pkg::PH_PREFIX;
      cand = 7'h7f;
      code = 0;
      neg = 0;
      seen_status = 0;
      uri_cnt = 0;
      reason_cnt = 0;
      meth = 0;
      hp = hst_pkg::HP_MATCH;
      kept = 0;
      trail = 0;
      cnt = 0;
      nl_seen = 0;
    endfunction

    function bit white(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function logic [7:0] lower(logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'h20 : b;
    endfunction

    function string method_text(int k);
      case (k)
        0: return "get ";
        1: return "post ";
        2: return "put ";
        3: return "delete ";
        4: return "head ";
        5: return "options ";
        default: return "HTTP/";
      endcase
    endfunction

    function logic [1:0] reason_byte(logic [7:0] b);
      if (b == 8'h0d) begin
        fl = hst_pkg::PH_DONE;
        return hst_pkg::ROLE_NONE;
      end
      if (reason_cnt < hst_pkg::ReasonMax) begin
        reason_cnt++;
        return hst_pkg::ROLE_REASON;
      end
      return hst_pkg::ROLE_NONE;
    endfunction

    function logic [1:0] start_line(logic [7:0] b);
      logic [6:0] alive;
      string      s;
      logic [7:0] got;
      alive = 0;
      case (fl)
        hst_pkg::PH_PREFIX: begin
          for (int k = 0; k < 7; k++) begin
            s = method_text(k);
            if (!cand[k] || loff >= s.len()) continue;
            got = (k < 6) ? lower(b) : b;
            if (got != s[loff]) continue;
            if (loff + 1 == s.len()) begin
              if (k < 6) begin
                meth = k + 1;
                fl = hst_pkg::PH_URI_SKIP;
              end else begin
                fl = hst_pkg::PH_VER_WS;
              end
              return hst_pkg::ROLE_NONE;
            end
            alive[k] = 1'b1;
          end
          cand = alive;
          if (alive == 0) fl = hst_pkg::PH_DONE;
          return hst_pkg::ROLE_NONE;
        end
        hst_pkg::PH_URI_SKIP: begin
          if (b == 8'h20) return hst_pkg::ROLE_NONE;
          fl = hst_pkg::PH_URI;
          uri_cnt++;
          return hst_pkg::ROLE_URI;
        end
        hst_pkg::PH_URI: begin
          if (b == 8'h20) begin
            fl = hst_pkg::PH_DONE;
            return hst_pkg::ROLE_NONE;
          end
          uri_cnt++;
          return hst_pkg::ROLE_URI;
        end
        hst_pkg::PH_VER_WS: begin
          if (!white(b)) fl = hst_pkg::PH_VER_TOK;
          return hst_pkg::ROLE_NONE;
        end
        hst_pkg::PH_VER_TOK: begin
          if (white(b)) fl = hst_pkg::PH_CODE_WS;
          return hst_pkg::ROLE_NONE;
        end
        hst_pkg::PH_CODE_WS, hst_pkg::PH_SIGN: begin
          if (fl == hst_pkg::PH_CODE_WS && white(b)) return hst_pkg::ROLE_NONE;
          if (fl == hst_pkg::PH_CODE_WS && (b == "+" || b == "-")) begin
            neg = (b == "-");
            fl = hst_pkg::PH_SIGN;
            return hst_pkg::ROLE_NONE;
          end
          if (!digit(b)) begin
            fl = hst_pkg::PH_DONE;
            return hst_pkg::ROLE_NONE;
          end
          seen_status = 1;
          code = b - "0";
          fl = hst_pkg::PH_DIGITS;
          return hst_pkg::ROLE_NONE;
        end
        hst_pkg::PH_DIGITS: begin
          if (digit(b)) begin
            code = code * 10 + (b - "0");
            if (code > 999) code = 999;
            return hst_pkg::ROLE_NONE;
          end
          if (white(b)) begin
            fl = hst_pkg::PH_REASON_WS;
            return hst_pkg::ROLE_NONE;
          end
          fl = hst_pkg::PH_REASON;
          return reason_byte(b);
        end
        hst_pkg::PH_REASON_WS: begin
          if (white(b)) return hst_pkg::ROLE_NONE;
          fl = hst_pkg::PH_REASON;
          return reason_byte(b);
        end
        hst_pkg::PH_REASON: return reason_byte(b);
        default: return hst_pkg::ROLE_NONE;
      endcase
    endfunction

    function logic [1:0] host_window(logic [7:0] b);
      logic [1:0] r;
      r = hst_pkg::ROLE_NONE;
      if (b == 0) begin
        hp = hst_pkg::HP_CLOSED;
        return hst_pkg::ROLE_NONE;
      end
      if (!(kept == 0 && white(b))) begin
        r = hst_pkg::ROLE_HOST;
        if (white(b)) begin
          trail++;
        end else begin
          kept += trail + 1;
          trail = 0;
        end
      end
      cnt++;
      if (cnt >= hst_pkg::HostMax) hp = hst_pkg::HP_CLOSED;
      return r;
    endfunction

    function logic [1:0] host_line(logic [7:0] b);
      string h;
      h = "host:";
      if (hp == hst_pkg::HP_FOUND) return hst_pkg::ROLE_NONE;
      if (b == 8'h0a) begin
        if (hp == hst_pkg::HP_SKIP_ST || hp == hst_pkg::HP_WINDOW ||
            hp == hst_pkg::HP_CLOSED) begin
          hp = hst_pkg::HP_FOUND;
        end else begin
          hp = hst_pkg::HP_MATCH;
          kept = 0;
          trail = 0;
          cnt = 0;
        end
        return hst_pkg::ROLE_NONE;
      end
      case (hp)
        hst_pkg::HP_MATCH: begin
          if (cnt < 5 && lower(b) == h[cnt]) begin
            cnt++;
            if (cnt == 5) begin
              cnt = 0;
              hp = hst_pkg::HP_SKIP_ST;
            end
          end else begin
            hp = hst_pkg::HP_SKIP_LINE;
          end
          return hst_pkg::ROLE_NONE;
        end
        hst_pkg::HP_SKIP_ST: begin
          if (b == 8'h20 || b == 8'h09) return hst_pkg::ROLE_NONE;
          hp = hst_pkg::HP_WINDOW;
          return host_window(b);
        end
        hst_pkg::HP_WINDOW: return host_window(b);
        default: return hst_pkg::ROLE_NONE;
      endcase
    endfunction

    // Notes an accepted input word and queues its predicted result word.
    function void note_input(logic [7:0] b, logic last);
      tag_word_t  w;
      logic [1:0] hr;
      w = '0;
      if (pos < 65535) pos++;
      if (!nl_seen) begin
        if (b == 8'h0a) begin
          nl_seen = 1;
          fl = hst_pkg::PH_DONE;
        end else if (fl != hst_pkg::PH_DONE) begin
          if (loff >= hst_pkg::FirstLineMax || b == 0) fl = hst_pkg::PH_DONE;
          else w.role = start_line(b);
        end
        if (loff < 255) loff++;
      end
      hr = host_line(b);
      if (hr != hst_pkg::ROLE_NONE) w.role = hr;
      w.echo = b;
      if (last) begin
        packets++;
        w.sum_valid = 1;
        w.pkt_len = 16'(pos);
        if (pos >= 4 && nl_seen) begin
          reported_pkts++;
          w.reported = 1;
          w.method = 3'(meth);
          w.status_present = seen_status;
          w.status_code = (seen_status && !neg) ? 10'(code) : 10'd0;
          w.uri_len = 8'(uri_cnt);
          w.reason_len = 6'(reason_cnt);
          w.host_len = (hp == hst_pkg::HP_FOUND) ? 7'(kept) : 7'd0;
          if (meth != 0) methods++;
          if (seen_status) statuses++;
          if (hp == hst_pkg::HP_FOUND && kept != 0) hosts_found++;
        end
        clear();
      end
      pending.push_back(w);
    endfunction

    function void check_result(tag_word_t a);
      tag_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected, echo %0h", a.echo);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.role != e.role) begin
        $error("byte_role exp %0d got %0d", e.role, a.role); errors++;
      end
      if (a.echo != e.echo) begin
        $error("echo_byte exp %0h got %0h", e.echo, a.echo); errors++;
      end
      if (a.sum_valid != e.sum_valid) begin
        $error("summary_valid exp %0d got %0d", e.sum_valid, a.sum_valid); errors++;
      end
      if (a.reported != e.reported) begin
        $error("reported exp %0d got %0d", e.reported, a.reported); errors++;
      end
      if (a.method != e.method) begin
        $error("method_code exp %0d got %0d", e.method, a.method); errors++;
      end
      if (a.status_present != e.status_present) begin
        $error("status_present exp %0d got %0d", e.status_present, a.status_present);
        errors++;
      end
      if (a.status_code != e.status_code) begin
        $error("status_code exp %0d got %0d", e.status_code, a.status_code); errors++;
      end
      if (a.uri_len != e.uri_len) begin
        $error("uri_length exp %0d got %0d", e.uri_len, a.uri_len); errors++;
      end
      if (a.reason_len != e.reason_len) begin
        $error("reason_length exp %0d got %0d", e.reason_len, a.reason_len); errors++;
      end
      if (a.host_len != e.host_len) begin
        $error("host_length exp %0d got %0d", e.host_len, a.host_len); errors++;
      end
      if (a.pkt_len != e.pkt_len) begin
        $error("packet_length exp %0d got %0d", e.pkt_len, a.pkt_len); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_payload_byte;
  logic        in_end_of_packet;
  logic        out_valid;
  logic        out_ready;
  tag_word_t   got;

  http_start_line_host_field_tagger u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_payload_byte(in_payload_byte), .in_end_of_packet(in_end_of_packet),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte_role(got.role), .out_echo_byte(got.echo),
    .out_summary_valid(got.sum_valid), .out_reported(got.reported),
    .out_method_code(got.method), .out_status_present(got.status_present),
    .out_status_code(got.status_code), .out_uri_length(got.uri_len),
    .out_reason_length(got.reason_len), .out_host_length(got.host_len),
    .out_packet_length(got.pkt_len)
  );

  tag_scoreboard sb = new();
  int            sent_words = 0;
  int            idle_count = 0;
  bit            calm = 0;      // no idling on either side
  bit            hold_off = 0;  // long receiver stall
  bit            stim_done = 0;
  logic [7:0]    pkt[$];

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Sends one word and returns at the edge that accepts it. Valid only drops
  // when the sender idles, so words can follow back to back.
  task automatic send_word(logic [7:0] b, logic last);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 16) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload_byte <= b;
    in_end_of_packet <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b, last);
    sent_words++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_word(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_token(int n);
    string cs;
    cs = "aZ09./-_:?%=\t\r ";
    for (int i = 0; i < n; i++) pkt.push_back(cs[$urandom_range(cs.len() - 1)]);
  endtask

  // Builds a random request or response, or a packet of random tokens or bytes.
  task automatic build_random_packet();
    string m[6];
    int    sel;
    m = '{"GET ", "post ", "PuT ", "DELETE ", "head ", "Options "};
    sel = $urandom_range(9);
    if (sel < 4) begin
      add_text(m[$urandom_range(5)]);
      if ($urandom_range(3) == 0) add_text("  ");
      add_token($urandom_range(1, 20));
      add_text(" HTTP/1.1\r\n");
    end else if (sel < 7) begin
      add_text("HTTP/1.");
      add_token($urandom_range(0, 2));
      add_text($urandom_range(3) == 0 ? " -" : " ");
      for (int i = $urandom_range(1, 5); i > 0; i--)
        pkt.push_back(8'("0" + $urandom_range(9)));
      add_text(" ");
      add_token($urandom_range(0, 70));
      add_text("\r\n");
    end else if (sel < 9) begin
      add_token($urandom_range(0, 10));
      if ($urandom_range(1)) add_text("\n");
    end else begin
      add_random($urandom_range(1, 12));
    end
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(1)) add_text("Accept: */*\r\n");
      add_text($urandom_range(1) ? "Host:" : "hOsT:");
      if ($urandom_range(1)) add_text(" \t");
      add_token($urandom_range(0, $urandom_range(9) == 0 ? 140 : 20));
      if ($urandom_range(7) == 0) pkt.push_back(8'h00);
      if ($urandom_range(7) != 0) add_text("\r\n");
    end
    if ($urandom_range(2) == 0) add_random($urandom_range(0, 6));
    if (pkt.size() == 0) pkt.push_back(8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 16);
      if (out_valid && out_ready) sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_count++;
      if (idle_count >= 5000) begin
        $display("simulation failed");
        $finish;
      end
    end else begin
      idle_count = 0;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload_byte = 8'h00;
    in_end_of_packet = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed packets: a request, a response with a saturating code, a host
    // window clipped by length, a negative code, short and newline-free packets.
    add_text("get /index.html HTTP/1.1\r\nHost:  example.org \r\n\r\n"); send_packet();
    add_text("HTTP/1.1 12345 Not Found\r\n"); send_packet();
    add_text("X\nHost:\t"); add_token(150); add_text("\n"); send_packet();
    add_text("HTTP/2 -4 x\n"); send_packet();
    add_text("a\n"); send_packet();
    add_text("OPTIONS * x"); send_packet();
    pkt.push_back(8'hff); pkt.push_back(8'h00); pkt.push_back(8'h0a);
    pkt.push_back(8'h55); send_packet();
    add_text("POST "); pkt.push_back(8'h00); add_text("q\nhost: a"); send_packet();
    add_text("HEAD "); add_token(210); add_text("\n"); send_packet();
    add_text("HTTP/1.0 200 "); add_token(70); add_text("\r\nHost: b\n"); send_packet();
    // Receiver stalls for a long stretch while the sender keeps offering words.
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      begin
        add_text("DELETE /x HTTP/1.1\nPUT a\n"); send_packet();
      end
    join
    while (sent_words < 1000) begin
      calm = (sent_words > 400 && sent_words < 600);
      build_random_packet();
      send_packet();
    end
    in_valid <= 1'b0;
    calm = 0;
    stim_done = 1;
  end

  initial begin
    int guard;
    guard = 0;
    wait (stim_done);
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d result words never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d words in %0d packets, %0d reported.", sent_words, sb.packets,
             sb.reported_pkts);
    $display("Summaries with a method: %0d, with a status: %0d, with a host: %0d.",
             sb.methods, sb.statuses, sb.hosts_found);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/hst_pkg.sv
sv/hst_front.sv
sv/hst_queue.sv
sv/hst_back.sv
sv/http_start_line_host_field_tagger.sv
tb/http_start_line_host_field_tagger_tb.sv
